### src/isp_pkg.sv
// ----------------------------------------------------------------------------
// Incremental speed PID package
// Field widths, register indexes, direction codes and arithmetic widths shared
// by the speed loop and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

  localparam int unsigned FINGERS_DEF = 5;

  localparam int unsigned FINGER_W   = 3;
  localparam int unsigned SETPOINT_W = 10;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Error is setpoint minus speed, which fits 17 signed bits.
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned INC_W   = SUM_W - FRAC_W;
  localparam int unsigned ACC_W   = INC_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd768;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd512;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd256;
  localparam logic [DUTY_W-1:0] DEAD_BAND_RST = 16'd10;
  localparam logic [DUTY_W-1:0] DUTY_FULL_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_ENABLE = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_DEAD_BAND   = 3'd4,
    CFG_DUTY_FULL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

endpackage

`default_nettype wire

### src/incremental_speed_pid.sv
// ----------------------------------------------------------------------------
// Incremental speed PID
// Per finger incremental PID speed loop with deadband, Q8.8 gains and a
// saturated duty accumulator for each finger.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid_i/in_stall_o  finger_i, setpoint_i, measured_speed_i,
//                                   direction_i
//  out       out_valid_o/out_stall_i out_finger_o, duty_o
//  cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word is accepted every cycle while in_stall_o is low; an accepted word
// passes the error stage register and then the multiply and scaling stage
// registers, and the accumulate stage feeds the output register.
// Reset clears all error and accumulator state and loads the default registers.
// A stalled result holds the output register; earlier stages keep filling
// until the pipeline is full, and only then is the input stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_speed_pid
  import isp_pkg::*;
#(
  parameter int unsigned FINGERS = FINGERS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [FINGER_W-1:0]   finger_i,
  input  wire logic [SETPOINT_W-1:0] setpoint_i,
  input  wire logic [SPEED_W-1:0]    measured_speed_i,
  input  wire logic [DIR_W-1:0]      direction_i,

  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [FINGER_W-1:0]   out_finger_o,
  output      logic [DUTY_W-1:0]     duty_o,

  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (FINGERS > 1) ? $clog2(FINGERS) : 1;

  // Configuration registers.
  logic              loop_enable_q;
  logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DUTY_W-1:0] dead_band_q, duty_full_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_enable_q <= 1'b0;
      gain_p_q      <= GAIN_P_RST;
      gain_i_q      <= GAIN_I_RST;
      gain_d_q      <= GAIN_D_RST;
      dead_band_q   <= DEAD_BAND_RST;
      duty_full_q   <= DUTY_FULL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOOP_ENABLE: loop_enable_q <= cfg_data_i[0];
        CFG_GAIN_P:      gain_p_q      <= cfg_data_i;
        CFG_GAIN_I:      gain_i_q      <= cfg_data_i;
        CFG_GAIN_D:      gain_d_q      <= cfg_data_i;
        CFG_DEAD_BAND:   dead_band_q   <= cfg_data_i;
        CFG_DUTY_FULL:   duty_full_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_stall_o = !s1_rdy;

  // Error stage: compute the error and step the per finger error history.
  logic                    in_acc;
  logic                    in_live;
  logic [IdxW-1:0]         in_idx;
  logic signed [ERR_W-1:0] err_raw, err_use;
  logic [ERR_W-1:0]        err_mag;

  logic signed [ERR_W-1:0] last_err_q  [FINGERS];
  logic signed [ERR_W-1:0] prior_err_q [FINGERS];

  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_live = in_acc && loop_enable_q &&
                   ({1'b0, finger_i} < (FINGER_W + 1)'(FINGERS));
  assign in_idx  = finger_i[IdxW-1:0];

  always_comb begin
    err_raw = $signed({{(ERR_W - SETPOINT_W){1'b0}}, setpoint_i}) -
              $signed({{(ERR_W - SPEED_W){1'b0}}, measured_speed_i});
    err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
    err_use = (err_mag < {{(ERR_W - DUTY_W){1'b0}}, dead_band_q}) ? '0 : err_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FINGERS; k++) begin
        last_err_q[k]  <= '0;
        prior_err_q[k] <= '0;
      end
    end else if (in_live) begin
      last_err_q[in_idx]  <= err_use;
      prior_err_q[in_idx] <= last_err_q[in_idx];
    end
  end

  logic [IdxW-1:0]         s1_idx_q;
  logic [FINGER_W-1:0]     s1_finger_q;
  logic [DIR_W-1:0]        s1_dir_q;
  logic signed [ERR_W-1:0] s1_e0_q, s1_e1_q, s1_e2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_idx_q    <= in_idx;
      s1_finger_q <= finger_i;
      s1_dir_q    <= direction_i;
      s1_e0_q     <= err_use;
      s1_e1_q     <= last_err_q[in_idx];
      s1_e2_q     <= prior_err_q[in_idx];
    end
  end

  // Multiply stage.
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic [IdxW-1:0]          s2_idx_q;
  logic [FINGER_W-1:0]      s2_finger_q;
  logic [DIR_W-1:0]         s2_dir_q;
  logic signed [PROD_W-1:0] s2_pp_q, s2_pi_q, s2_pd_q;

  always_comb begin
    prod_p = $signed({1'b0, gain_p_q}) * s1_e0_q;
    prod_i = $signed({1'b0, gain_i_q}) * s1_e1_q;
    prod_d = $signed({1'b0, gain_d_q}) * s1_e2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_idx_q    <= s1_idx_q;
      s2_finger_q <= s1_finger_q;
      s2_dir_q    <= s1_dir_q;
      s2_pp_q     <= prod_p;
      s2_pi_q     <= prod_i;
      s2_pd_q     <= prod_d;
    end
  end

  // Scaling stage: add the P and D products, subtract the I product and divide by 256 with truncation toward zero.
  logic signed [SUM_W-1:0] pid_sum, pid_biased, pid_shift;
  logic [IdxW-1:0]         s3_idx_q;
  logic [FINGER_W-1:0]     s3_finger_q;
  logic [DIR_W-1:0]        s3_dir_q;
  logic signed [INC_W-1:0] s3_inc_q;

  always_comb begin
    pid_sum    = SUM_W'(s2_pp_q) - SUM_W'(s2_pi_q) + SUM_W'(s2_pd_q);
    pid_biased = pid_sum + (pid_sum[SUM_W-1] ? $signed(SUM_W'((1 << FRAC_W) - 1))
                                             : $signed(SUM_W'(0)));
    pid_shift  = pid_biased >>> FRAC_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_idx_q    <= s2_idx_q;
      s3_finger_q <= s2_finger_q;
      s3_dir_q    <= s2_dir_q;
      s3_inc_q    <= INC_W'(pid_shift);
    end
  end

  // Accumulate stage: saturate, store the magnitude and form the duty.
  logic [DUTY_W-1:0]       accum_q [FINGERS];
  logic signed [ACC_W-1:0] acc_sum, acc_lim, acc_abs;
  logic [DUTY_W-1:0]       duty_new, duty_out;
  logic                    s3_fire, s3_emit;

  assign s3_fire = s3_v_q && out_rdy;
  assign s3_emit = (s3_dir_q == DIR_UP) || (s3_dir_q == DIR_DOWN);

  always_comb begin
    acc_sum = ACC_W'($signed({1'b0, accum_q[s3_idx_q]})) + ACC_W'(s3_inc_q);
    acc_lim = $signed({{(ACC_W - DUTY_W){1'b0}}, duty_full_q});
    acc_abs = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;
    if ((acc_sum > acc_lim) || (acc_sum < -acc_lim)) begin
      duty_new = duty_full_q;
    end else begin
      duty_new = DUTY_W'(acc_abs);
    end
    duty_out = (s3_dir_q == DIR_DOWN) ? (duty_full_q - duty_new) : duty_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FINGERS; k++) begin
        accum_q[k] <= '0;
      end
    end else if (s3_fire) begin
      accum_q[s3_idx_q] <= duty_new;
    end
  end

  // Output register.
  logic [FINGER_W-1:0] out_finger_q;
  logic [DUTY_W-1:0]   duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= s3_v_q && s3_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_finger_q <= s3_finger_q;
      duty_q       <= duty_out;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_finger_o = out_finger_q;
  assign duty_o       = duty_q;

endmodule

`default_nettype wire

### src/isp_checker.sv
// ----------------------------------------------------------------------------
// Incremental speed PID checker
// Port level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_checker
  import isp_pkg::*;
#(
  parameter int unsigned FINGERS = FINGERS_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [FINGER_W-1:0] out_finger_o,
  input wire logic [DUTY_W-1:0]   duty_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(duty_o) && $stable(out_finger_o))
    else $error("result payload changed while stalled");

  // Results only name fingers that have a loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_finger_o} < (FINGER_W + 1)'(FINGERS)))
    else $error("result for a finger without a loop");

  // No result is offered in the cycle after reset.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered out of reset");

endmodule

bind incremental_speed_pid isp_checker #(.FINGERS(FINGERS)) u_isp_checker (.*);

`default_nettype wire
